// File: hdl/grc_pkg.sv
// Shared types, constants and the tangent table builder for grid_ray_caster.
// Depends on nothing; used by every other file in this folder.
package grc_pkg;

    localparam int MAP_SIDE   = 64;
    localparam int ANGLE_BITS = 12;
    localparam int FRAC_BITS  = 10;

    localparam int TILE_BITS  = $clog2(MAP_SIDE);
    localparam int COORD_BITS = 16;
    localparam int DIM_BITS   = 7;
    localparam int DIST_BITS  = 17;
    localparam int CW         = TILE_BITS + FRAC_BITS + 3;
    localparam int MAG_BITS   = CW - 1;
    localparam int TW         = $clog2(2 * MAP_SIDE) + FRAC_BITS + 1;
    localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
    localparam int RW         = 2 * MAG_BITS + 2;
    localparam int ROOT_ITERS = RW / 2;
    localparam int CNT_BITS   = $clog2(ROOT_ITERS);

    localparam logic [TW-1:0]        TAN_MAX   = TW'((2 * MAP_SIDE) << FRAC_BITS);
    localparam logic [DIST_BITS-1:0] MISS_DIST = DIST_BITS'(100 << FRAC_BITS);
    localparam logic [63:0]          HALF_PI_Q30 = 64'd1686629713;

    localparam logic [7:0] CODE_DIGIT_LO = 8'h31;
    localparam logic [7:0] CODE_DIGIT_HI = 8'h39;
    localparam logic [7:0] CODE_UPPER_LO = 8'h41;
    localparam logic [7:0] CODE_UPPER_HI = 8'h5A;
    localparam logic [7:0] CODE_DOOR     = 8'h64;

    typedef enum logic {
        OP_CAST = 1'b0,
        OP_TILE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_MAP_WIDTH  = 2'd0,
        CFG_MAP_HEIGHT = 2'd1,
        CFG_VIEWER_X   = 2'd2,
        CFG_VIEWER_Y   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [ANGLE_BITS-1:0] ray_angle;
        logic [TILE_BITS-1:0]  tile_col;
        logic [TILE_BITS-1:0]  tile_row;
        logic [7:0]            tile_code;
    } request_t;

    typedef struct packed {
        logic                  hit;
        logic [DIST_BITS-1:0]  distance;
        logic                  side;
        logic [COORD_BITS-1:0] hit_x;
        logic [COORD_BITS-1:0] hit_y;
    } result_t;

    typedef struct packed {
        logic [DIM_BITS-1:0]   map_width;
        logic [DIM_BITS-1:0]   map_height;
        logic [COORD_BITS-1:0] viewer_x;
        logic [COORD_BITS-1:0] viewer_y;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAN_A,
        ST_TAN_B,
        ST_COT_B,
        ST_W_INIT,
        ST_W_SEC,
        ST_W_CHECK,
        ST_W_READ,
        ST_D_SQ,
        ST_D_SUM,
        ST_SQRT,
        ST_D_STORE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic tile_wr;
        logic load;
        logic rom_sel_cot;
        logic cap_tan;
        logic cap_cot;
        logic set_axis;
        logic axis_val;
        logic walk_init;
        logic walk_sec;
        logic walk_step;
        logic hit_cap;
        logic sq;
        logic sqrt_init;
        logic sqrt_step;
        logic dist_store;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic skip_v;
        logic skip_h;
        logic axis_h;
        logic in_range;
        logic wall;
    } ctrl_status_t;

    typedef logic [TW-1:0] tan_rom_t [QUARTER];

    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // |tan| within a quadrant from Taylor series of sine and cosine in Q2.30
    function automatic logic [TW-1:0] tan_quad(input logic [63:0] k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] sp;
        logic [63:0] sn;
        logic [63:0] cp;
        logic [63:0] cn;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] t;
        if (k >= 64'(QUARTER))
            return TAN_MAX;
        x  = (k * HALF_PI_Q30) >> (ANGLE_BITS - 2);
        x2 = (x * x) >> 30;
        ts = x;
        sp = x;
        sn = '0;
        tc = 64'd1 << 30;
        cp = 64'd1 << 30;
        cn = '0;
        for (int n = 1; n <= 9; n++)
        begin
            ts = udiv64((ts * x2) >> 30, 64'((2 * n) * (2 * n + 1)));
            tc = udiv64((tc * x2) >> 30, 64'((2 * n - 1) * (2 * n)));
            if ((n & 1) == 1)
            begin
                sn = sn + ts;
                cn = cn + tc;
            end
            else
            begin
                sp = sp + ts;
                cp = cp + tc;
            end
        end
        s = (sp >= sn) ? sp - sn : 64'd0;
        c = (cp >= cn) ? cp - cn : 64'd0;
        if (c == 64'd0)
            return TAN_MAX;
        t = udiv64((s << FRAC_BITS) + (c >> 1), c);
        if (t > 64'(TAN_MAX))
            return TAN_MAX;
        return t[TW-1:0];
    endfunction

    function automatic tan_rom_t build_tan_rom();
        tan_rom_t rom;
        for (int k = 0; k < QUARTER; k++)
            rom[k] = tan_quad(64'(k));
        return rom;
    endfunction

endpackage

// File: hdl/grc_ctrl.sv
// Sequencer for grid_ray_caster: table reads, up to two grid walks, root, result.
// Depends on grc_pkg.
module grc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  grc_pkg::opcode_t      opcode,
    input  grc_pkg::ctrl_status_t status,
    output grc_pkg::ctrl_cmd_t    cmd,
    output logic                  busy,
    output logic                  done
);

    grc_pkg::state_t state_reg;
    grc_pkg::state_t state_next;
    logic [grc_pkg::CNT_BITS-1:0] cnt_reg;
    logic [grc_pkg::CNT_BITS-1:0] cnt_next;
    logic done_reg;
    logic done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grc_pkg::ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            grc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == grc_pkg::OP_TILE)
                        cmd.tile_wr = 1'b1;
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = grc_pkg::ST_TAN_A;
                    end
                end
            end
            grc_pkg::ST_TAN_A:
            begin
                state_next = grc_pkg::ST_TAN_B;
            end
            grc_pkg::ST_TAN_B:
            begin
                cmd.cap_tan     = 1'b1;
                cmd.rom_sel_cot = 1'b1;
                state_next      = grc_pkg::ST_COT_B;
            end
            grc_pkg::ST_COT_B:
            begin
                cmd.cap_cot  = 1'b1;
                cmd.set_axis = 1'b1;
                if (!status.skip_v)
                begin
                    cmd.axis_val = 1'b0;
                    state_next   = grc_pkg::ST_W_INIT;
                end
                else if (!status.skip_h)
                begin
                    cmd.axis_val = 1'b1;
                    state_next   = grc_pkg::ST_W_INIT;
                end
                else
                    state_next = grc_pkg::ST_FINISH;
            end
            grc_pkg::ST_W_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = grc_pkg::ST_W_SEC;
            end
            grc_pkg::ST_W_SEC:
            begin
                cmd.walk_sec = 1'b1;
                state_next   = grc_pkg::ST_W_CHECK;
            end
            grc_pkg::ST_W_CHECK:
            begin
                if (status.in_range)
                    state_next = grc_pkg::ST_W_READ;
                else if (!status.axis_h && !status.skip_h)
                begin
                    cmd.set_axis = 1'b1;
                    cmd.axis_val = 1'b1;
                    state_next   = grc_pkg::ST_W_INIT;
                end
                else
                    state_next = grc_pkg::ST_FINISH;
            end
            grc_pkg::ST_W_READ:
            begin
                if (status.wall)
                begin
                    cmd.hit_cap = 1'b1;
                    state_next  = grc_pkg::ST_D_SQ;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = grc_pkg::ST_W_CHECK;
                end
            end
            grc_pkg::ST_D_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = grc_pkg::ST_D_SUM;
            end
            grc_pkg::ST_D_SUM:
            begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = grc_pkg::ST_SQRT;
            end
            grc_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == grc_pkg::CNT_BITS'(grc_pkg::ROOT_ITERS - 1))
                    state_next = grc_pkg::ST_D_STORE;
            end
            grc_pkg::ST_D_STORE:
            begin
                cmd.dist_store = 1'b1;
                if (!status.axis_h && !status.skip_h)
                begin
                    cmd.set_axis = 1'b1;
                    cmd.axis_val = 1'b1;
                    state_next   = grc_pkg::ST_W_INIT;
                end
                else
                    state_next = grc_pkg::ST_FINISH;
            end
            grc_pkg::ST_FINISH:
            begin
                cmd.out_load = 1'b1;
                done_next    = 1'b1;
                state_next   = grc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = grc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != grc_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

// File: hdl/grc_datapath.sv
// Datapath for grid_ray_caster: wall map memory, tangent table, walk registers,
// squared-distance and bitwise square root unit, result register. Depends on grc_pkg.
module grc_datapath
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  grc_pkg::ctrl_cmd_t    cmd,
    input  grc_pkg::cfg_t         cfg,
    input  grc_pkg::request_t     req,
    output grc_pkg::ctrl_status_t status,
    output grc_pkg::result_t      result
);

    localparam int F  = grc_pkg::FRAC_BITS;
    localparam int CW = grc_pkg::CW;
    localparam int TW = grc_pkg::TW;
    localparam int TB = grc_pkg::TILE_BITS;
    localparam int MB = grc_pkg::MAG_BITS;
    localparam int RW = grc_pkg::RW;
    localparam int AB = grc_pkg::ANGLE_BITS;
    localparam int XB = grc_pkg::COORD_BITS;
    localparam int DB = grc_pkg::DIST_BITS;
    localparam grc_pkg::tan_rom_t TAN_ROM = grc_pkg::build_tan_rom();
    localparam logic signed [CW-1:0] ONE = CW'(1 << F);

    logic wall_mem [grc_pkg::MAP_SIDE * grc_pkg::MAP_SIDE];
    logic mem_q_reg;

    logic [1:0]      quad_reg;
    logic [AB-3:0]   rem_reg;
    logic [TW-1:0]   rom_q_reg;
    logic [TW-1:0]   tan_reg;
    logic [TW-1:0]   cot_reg;
    logic            axis_reg;

    logic signed [CW-1:0] p_reg;
    logic signed [CW-1:0] s_reg;
    logic [F:0]           dp_reg;
    logic [MB-1:0]        ep_reg;
    logic [MB-1:0]        es_reg;
    logic [2*MB-1:0]      sqa_reg;
    logic [2*MB-1:0]      sqb_reg;
    logic [RW-1:0]        v_reg;
    logic [RW-1:0]        r_reg;
    logic [RW-1:0]        bit_reg;
    logic [XB-1:0]        hp_reg;
    logic [XB-1:0]        hs_reg;

    logic          vhit_reg;
    logic          hhit_reg;
    logic [XB-1:0] vx_reg;
    logic [XB-1:0] vy_reg;
    logic [XB-1:0] hx_reg;
    logic [XB-1:0] hy_reg;
    logic [DB-1:0] dv_reg;
    logic [DB-1:0] dh_reg;
    grc_pkg::result_t result_reg;

    logic [AB-2:0]   rom_idx_wide;
    logic [AB-3:0]   rom_addr;
    logic            rom_max;
    logic [TW-1:0]   rom_val;
    logic            xpos;
    logic            ypos;
    logic            pfwd;
    logic            sfwd;
    logic [XB-1:0]   p0;
    logic [XB-1:0]   s0;
    logic [TW-1:0]   slope;
    logic [grc_pkg::DIM_BITS-1:0] w_eff;
    logic [grc_pkg::DIM_BITS-1:0] h_eff;
    logic signed [CW-1:0] plim;
    logic signed [CW-1:0] slim;
    logic [CW-1:0]   p_start;
    logic [CW-1:0]   dp_full;
    logic [TW+F:0]   ds_prod;
    logic [TW+F:0]   ds_round;
    logic signed [CW-1:0] ds;
    logic signed [CW-1:0] s_init;
    logic            in_range;
    logic [TB-1:0]   tp;
    logic [TB-1:0]   ts;
    logic [2*TB-1:0] rd_addr;
    logic [2*TB-1:0] wr_addr;
    logic            tile_wall;
    logic signed [CW-1:0] ep_s;
    logic signed [CW-1:0] es_s;
    logic [RW-1:0]   trial;
    logic [DB-1:0]   dist_sat;

    // tangent table read; cotangent uses the complementary angle
    always_comb
    begin
        rom_idx_wide = cmd.rom_sel_cot ? (AB-1)'(grc_pkg::QUARTER) - {1'b0, rem_reg}
                                       : {1'b0, rem_reg};
        if (quad_reg[0])
            rom_idx_wide = cmd.rom_sel_cot ? {1'b0, rem_reg}
                                           : (AB-1)'(grc_pkg::QUARTER) - {1'b0, rem_reg};
        rom_max  = rom_idx_wide[AB-2];
        rom_addr = rom_idx_wide[AB-3:0];
    end

    assign rom_val = rom_max ? grc_pkg::TAN_MAX : TAN_ROM[rom_addr];

    always_comb
    begin
        xpos  = (quad_reg == 2'd0) || (quad_reg == 2'd3);
        ypos  = (quad_reg == 2'd0) || (quad_reg == 2'd1);
        pfwd  = axis_reg ? ypos : xpos;
        sfwd  = axis_reg ? xpos : ypos;
        p0    = axis_reg ? cfg.viewer_y : cfg.viewer_x;
        s0    = axis_reg ? cfg.viewer_x : cfg.viewer_y;
        slope = axis_reg ? cot_reg : tan_reg;
        w_eff = (cfg.map_width > grc_pkg::DIM_BITS'(grc_pkg::MAP_SIDE))
              ? grc_pkg::DIM_BITS'(grc_pkg::MAP_SIDE) : cfg.map_width;
        h_eff = (cfg.map_height > grc_pkg::DIM_BITS'(grc_pkg::MAP_SIDE))
              ? grc_pkg::DIM_BITS'(grc_pkg::MAP_SIDE) : cfg.map_height;
        plim  = axis_reg ? (CW'(h_eff) << F) : (CW'(w_eff) << F);
        slim  = axis_reg ? (CW'(w_eff) << F) : (CW'(h_eff) << F);

        p_start  = (CW'(p0[XB-1:F]) + CW'(pfwd)) << F;
        dp_full  = pfwd ? p_start - CW'(p0) : CW'(p0) - p_start;
        ds_prod  = (TW+F+1)'(slope) * (TW+F+1)'(dp_reg);
        ds_round = (ds_prod + (TW+F+1)'(1 << (F - 1))) >> F;
        ds       = CW'(ds_round);
        s_init   = sfwd ? $signed(CW'(s0)) + ds : $signed(CW'(s0)) - ds;

        in_range = (p_reg >= 0) && (p_reg < plim) && (s_reg >= 0) && (s_reg < slim)
                 && !(!pfwd && (p_reg < ONE));
        tp = p_reg[F+TB-1:F] - TB'(!pfwd);
        ts = s_reg[F+TB-1:F];
        rd_addr = axis_reg ? {tp, ts} : {ts, tp};
        wr_addr = {req.tile_row, req.tile_col};

        tile_wall = ((req.tile_code >= grc_pkg::CODE_DIGIT_LO)
                     && (req.tile_code <= grc_pkg::CODE_DIGIT_HI))
                 || ((req.tile_code >= grc_pkg::CODE_UPPER_LO)
                     && (req.tile_code <= grc_pkg::CODE_UPPER_HI))
                 || (req.tile_code == grc_pkg::CODE_DOOR);

        ep_s     = p_reg - $signed(CW'(p0));
        es_s     = s_reg - $signed(CW'(s0));
        trial    = r_reg + bit_reg;
        dist_sat = (r_reg > RW'(grc_pkg::MISS_DIST)) ? grc_pkg::MISS_DIST : r_reg[DB-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tile_wr)
            wall_mem[wr_addr] <= tile_wall;
        mem_q_reg <= wall_mem[rd_addr];
        rom_q_reg <= rom_val;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quad_reg <= req.ray_angle[AB-1:AB-2];
            rem_reg  <= req.ray_angle[AB-3:0];
        end
        if (cmd.cap_tan)
            tan_reg <= rom_q_reg;
        if (cmd.cap_cot)
            cot_reg <= rom_q_reg;
        if (cmd.set_axis)
            axis_reg <= cmd.axis_val;
        if (cmd.walk_init)
        begin
            p_reg  <= $signed(p_start);
            dp_reg <= dp_full[F:0];
        end
        if (cmd.walk_sec)
            s_reg <= s_init;
        if (cmd.walk_step)
        begin
            p_reg <= pfwd ? p_reg + ONE : p_reg - ONE;
            s_reg <= sfwd ? s_reg + $signed(CW'(slope)) : s_reg - $signed(CW'(slope));
        end
        if (cmd.hit_cap)
        begin
            hp_reg <= pfwd ? p_reg[XB-1:0] : XB'(p_reg - ONE);
            hs_reg <= s_reg[XB-1:0];
            ep_reg <= ep_s[CW-1] ? MB'(-ep_s) : MB'(ep_s);
            es_reg <= es_s[CW-1] ? MB'(-es_s) : MB'(es_s);
        end
        if (cmd.sq)
        begin
            sqa_reg <= ep_reg * ep_reg;
            sqb_reg <= es_reg * es_reg;
        end
        if (cmd.sqrt_init)
        begin
            v_reg   <= RW'(sqa_reg) + RW'(sqb_reg);
            r_reg   <= '0;
            bit_reg <= RW'(1) << (RW - 2);
        end
        if (cmd.sqrt_step)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
                r_reg <= r_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vhit_reg <= 1'b0;
            hhit_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            vhit_reg <= 1'b0;
            hhit_reg <= 1'b0;
        end
        else if (cmd.dist_store)
        begin
            if (axis_reg)
                hhit_reg <= 1'b1;
            else
                vhit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dv_reg <= grc_pkg::MISS_DIST;
            dh_reg <= grc_pkg::MISS_DIST;
            vx_reg <= '0;
            vy_reg <= '0;
            hx_reg <= '0;
            hy_reg <= '0;
        end
        else if (cmd.dist_store)
        begin
            if (axis_reg)
            begin
                dh_reg <= dist_sat;
                hx_reg <= hs_reg;
                hy_reg <= hp_reg;
            end
            else
            begin
                dv_reg <= dist_sat;
                vx_reg <= hp_reg;
                vy_reg <= hs_reg;
            end
        end
        if (cmd.out_load)
        begin
            if (dv_reg <= dh_reg)
            begin
                result_reg.hit      <= vhit_reg;
                result_reg.distance <= dv_reg;
                result_reg.side     <= 1'b0;
                result_reg.hit_x    <= vx_reg;
                result_reg.hit_y    <= vy_reg;
            end
            else
            begin
                result_reg.hit      <= hhit_reg;
                result_reg.distance <= dh_reg;
                result_reg.side     <= 1'b1;
                result_reg.hit_x    <= hx_reg;
                result_reg.hit_y    <= hy_reg;
            end
        end
    end

    assign status.skip_v   = (rem_reg == '0) && quad_reg[0];
    assign status.skip_h   = (rem_reg == '0) && !quad_reg[0];
    assign status.axis_h   = axis_reg;
    assign status.in_range = in_range;
    assign status.wall     = mem_q_reg;
    assign result          = result_reg;

endmodule

// File: hdl/grid_ray_caster.sv
// Tile-map ray caster: one request per cast or tile write, one result per cast.
// A tile write gives no result. A cast reads the tangent table, then per walk runs
// a setup and one map read per grid crossing until it leaves the map on a miss or
// hits a wall, then the squared distance and the 19-step root on a hit. One request
// at a time; busy is high until the result strobe. No backpressure. Reset sets map
// size 64x64 and viewer 0,0; map contents are undefined until written.
module grid_ray_caster
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  grc_pkg::request_t request,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output logic              done,
    output grc_pkg::result_t  result
);

    grc_pkg::cfg_t         cfg_reg;
    grc_pkg::ctrl_cmd_t    cmd;
    grc_pkg::ctrl_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width  <= grc_pkg::DIM_BITS'(64);
            cfg_reg.map_height <= grc_pkg::DIM_BITS'(64);
            cfg_reg.viewer_x   <= '0;
            cfg_reg.viewer_y   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (grc_pkg::cfg_index_t'(cfg_index))
                grc_pkg::CFG_MAP_WIDTH:  cfg_reg.map_width  <= cfg_data[grc_pkg::DIM_BITS-1:0];
                grc_pkg::CFG_MAP_HEIGHT: cfg_reg.map_height <= cfg_data[grc_pkg::DIM_BITS-1:0];
                grc_pkg::CFG_VIEWER_X:   cfg_reg.viewer_x   <= cfg_data;
                grc_pkg::CFG_VIEWER_Y:   cfg_reg.viewer_y   <= cfg_data;
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    grc_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (request.opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    grc_datapath u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .req    (request),
        .status (status),
        .result (result)
    );

endmodule
